/* rtl/core/stereo_point_fusion_assert.svh */
// Assertion macros shared by the stereo point fusion RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef STEREO_POINT_FUSION_ASSERT_SVH
`define STEREO_POINT_FUSION_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define SPF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define SPF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/spf_pkg.sv */
// Package for the stereo point fusion block: widths, pipeline depths, mode codes.
// Depends on nothing; used by every RTL module of the block.
`timescale 1ns / 1ps

package spf_pkg;

  localparam int COORD_W = 32;              // signed Q16.16 coordinate
  localparam int SQ_W = 2 * COORD_W;         // square of one absolute difference
  localparam int RAD_W = SQ_W + 2;           // sum of three squares
  localparam int DIST_W = RAD_W / 2;         // floor square root
  localparam int SQRT_STAGES = DIST_W;       // one root bit per stage
  localparam int DIST_LAT = 3 + SQRT_STAGES; // diff, square, sum, then root

  localparam int NUM_W = DIST_W + 1;
  localparam int DEN_W = DIST_W + 1;
  localparam int PROD_W = COORD_W + NUM_W;
  localparam int QUO_W = COORD_W + 1;        // quotient stays below 2^33
  localparam int DIV_STAGES = QUO_W;         // one quotient bit per stage
  localparam int BLEND_LAT = DIV_STAGES + 4; // two multiply, divide, round, output
  localparam int TOTAL_LAT = 2 + DIST_LAT + BLEND_LAT;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [1:0] MODE_MEAN = 2'd0;
  localparam logic [1:0] MODE_DIST = 2'd1;
  localparam logic [1:0] MODE_INVD = 2'd2;

  localparam logic REG_FUSION_MODE = 1'b0;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

/* rtl/core/spf_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on spf_pkg for widths.
`timescale 1ns / 1ps

module spf_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  logic [spf_pkg::RAD_W-1:0]  radicand,
  output logic                       out_vld,
  output logic [spf_pkg::DIST_W-1:0] root
);

  localparam int RW = spf_pkg::RAD_W;
  localparam int DW = spf_pkg::DIST_W;
  localparam int NS = spf_pkg::SQRT_STAGES;

  logic [RW-1:0] rem [0:NS];
  logic [DW-1:0] r   [0:NS];
  logic          vld [0:NS];

  assign rem[0] = radicand;
  assign r[0]   = '0;
  assign vld[0] = in_vld;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = DW - 1 - s;
    logic [RW:0] delta;
    logic [RW:0] rem_sub;
    logic        take;

    // (r + 2^B)^2 - r^2; r has no bits at or below B yet, so the terms do not overlap.
    assign delta   = ({{(RW + 1 - DW){1'b0}}, r[s]} << (B + 1)) | ((RW + 1)'(1) << (2 * B));
    assign rem_sub = {1'b0, rem[s]} - delta;
    assign take    = {1'b0, rem[s]} >= delta;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= take ? rem_sub[RW-1:0] : rem[s];
      r[s+1]   <= take ? (r[s] | (DW'(1) << B)) : r[s];
    end
  end

  assign out_vld = vld[NS];
  assign root    = r[NS];

endmodule

/* rtl/core/spf_dist.sv */
// Distance from a camera centre to a point: absolute differences, squares, sum, root.
// Depends on spf_pkg and spf_sqrt.
`timescale 1ns / 1ps

module spf_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  spf_pkg::coord_t            pt  [3],
  input  spf_pkg::coord_t            cam [3],
  output logic                       out_vld,
  output logic [spf_pkg::DIST_W-1:0] distance
);

  localparam int CW = spf_pkg::COORD_W;

  logic [CW:0]               diff [3];
  logic [CW-1:0]             ad   [3];
  logic [spf_pkg::SQ_W-1:0]  sq   [3];
  logic [spf_pkg::RAD_W-1:0] sum;
  logic                      v1;
  logic                      v2;
  logic                      v3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pt[i][CW-1], pt[i]} - {cam[i][CW-1], cam[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ad[i] <= diff[i][CW] ? (~diff[i][CW-1:0] + 1'b1) : diff[i][CW-1:0];
      sq[i] <= ad[i] * ad[i];
    end
    sum <= spf_pkg::RAD_W'(sq[0]) + spf_pkg::RAD_W'(sq[1]) + spf_pkg::RAD_W'(sq[2]);
  end

  spf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v3),
    .radicand (sum),
    .out_vld  (out_vld),
    .root     (distance)
  );

endmodule

/* rtl/core/spf_blend.sv */
// One coordinate of base +/- mag*num/den, rounded half away from zero and saturated.
// Split multiply, pipelined restoring divide, rounding and output stages. Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  spf_pkg::coord_t             base,
  input  logic                        neg,
  input  logic [spf_pkg::COORD_W-1:0] mag,
  input  logic [spf_pkg::NUM_W-1:0]   num,
  input  logic [spf_pkg::DEN_W-1:0]   den,
  output logic                        out_vld,
  output spf_pkg::coord_t             res
);

  localparam int CW = spf_pkg::COORD_W;
  localparam int PW = spf_pkg::PROD_W;
  localparam int QW = spf_pkg::QUO_W;
  localparam int DNW = spf_pkg::DEN_W;
  localparam int NS = spf_pkg::DIV_STAGES;
  localparam int HW = spf_pkg::NUM_W - CW;
  localparam int SW = CW + 4;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

  // Multiply stage one: partial products.
  logic [2*CW-1:0]  pp_lo;
  logic [CW+HW-1:0] pp_hi;
  spf_pkg::coord_t  m_base;
  logic             m_neg;
  logic [DNW-1:0]   m_den;
  logic             m_vld;

  // Divider stage registers; index 0 holds the summed product.
  logic [DNW-1:0]   rem    [0:NS];
  logic [QW-1:0]    low    [0:NS];
  spf_pkg::coord_t  base_s [0:NS];
  logic             neg_s  [0:NS];
  logic [DNW-1:0]   den_s  [0:NS];
  logic             vld_s  [0:NS];
  logic [PW-1:0]    prod;

  // Rounding stage.
  logic [QW:0]      q_r;
  spf_pkg::coord_t  base_r;
  logic             neg_r;
  logic             vld_r;
  logic             up;
  logic signed [SW-1:0] wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld    <= 1'b0;
      vld_s[0] <= 1'b0;
    end else begin
      m_vld    <= in_vld;
      vld_s[0] <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo     <= mag * num[CW-1:0];
    pp_hi     <= mag * num[spf_pkg::NUM_W-1:CW];
    m_base    <= base;
    m_neg     <= neg;
    m_den     <= den;
    prod      <= PW'(pp_lo) + (PW'(pp_hi) << CW);
    base_s[0] <= m_base;
    neg_s[0]  <= m_neg;
    den_s[0]  <= m_den;
  end

  // The quotient is known to fit QW bits, so the top of the product starts below den.
  assign rem[0] = DNW'(prod[PW-1:QW]);
  assign low[0] = prod[QW-1:0];

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [DNW:0] shifted;
    logic [DNW:0] sub;
    logic         ge;

    assign shifted = {rem[s], low[s][QW-1]};
    assign sub     = shifted - {1'b0, den_s[s]};
    assign ge      = shifted >= {1'b0, den_s[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[s+1] <= 1'b0;
      end else begin
        vld_s[s+1] <= vld_s[s];
      end
    end

    // Dividend bits shift out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge clk) begin
      rem[s+1]    <= ge ? sub[DNW-1:0] : shifted[DNW-1:0];
      low[s+1]    <= {low[s][QW-2:0], ge};
      base_s[s+1] <= base_s[s];
      neg_s[s+1]  <= neg_s[s];
      den_s[s+1]  <= den_s[s];
    end
  end

  assign up = rem[NS] >= (den_s[NS] - rem[NS]);

  always_comb begin
    if (neg_r) begin
      wide = $signed({{4{base_r[CW-1]}}, base_r}) - $signed({2'b00, q_r});
    end else begin
      wide = $signed({{4{base_r[CW-1]}}, base_r}) + $signed({2'b00, q_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld_r   <= vld_s[NS];
      out_vld <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= {1'b0, low[NS]} + (QW + 1)'(up);
    base_r <= base_s[NS];
    neg_r  <= neg_s[NS];
    if (wide > SAT_MAX) begin
      res <= spf_pkg::coord_t'(SAT_MAX[CW-1:0]);
    end else if (wide < SAT_MIN) begin
      res <= spf_pkg::coord_t'(SAT_MIN[CW-1:0]);
    end else begin
      res <= spf_pkg::coord_t'(wide[CW-1:0]);
    end
  end

endmodule

/* rtl/core/stereo_point_fusion.sv */
// Top level of the stereo point fusion block: register port, input stage,
// mode select and output. Depends on spf_pkg, spf_dist, spf_blend and the assert header.
//
//   Channel   Handshake               Contents
//   config    psel/penable/pwrite     fusion_mode at byte address 0
//   input     start (busy tied low)   current and earlier camera centres and points
//   result    done, one cycle         fused_x, fused_y, fused_z
//
// A new point is taken in every cycle. Each result follows its transfer through the
// 33-stage square root and the 33-stage divider in series.
// Reset clears the mode register and every valid bit; no clearing pass is needed.
// The result side cannot stall, so the pipeline never holds and busy stays low.
`timescale 1ns / 1ps

`include "stereo_point_fusion_assert.svh"

module stereo_point_fusion (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spf_pkg::ADDR_W-1:0]  paddr,
  input  logic [spf_pkg::DATA_W-1:0]  pwdata,
  output logic [spf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          cur_cam_x,
  input  logic signed [31:0]          cur_cam_y,
  input  logic signed [31:0]          cur_cam_z,
  input  logic signed [31:0]          cur_pt_x,
  input  logic signed [31:0]          cur_pt_y,
  input  logic signed [31:0]          cur_pt_z,
  input  logic signed [31:0]          old_cam_x,
  input  logic signed [31:0]          old_cam_y,
  input  logic signed [31:0]          old_cam_z,
  input  logic signed [31:0]          old_pt_x,
  input  logic signed [31:0]          old_pt_y,
  input  logic signed [31:0]          old_pt_z,
  output logic                        done,
  output logic signed [31:0]          fused_x,
  output logic signed [31:0]          fused_y,
  output logic signed [31:0]          fused_z
);

  localparam int CW = spf_pkg::COORD_W;
  localparam int DL = spf_pkg::DIST_LAT;
  localparam int DW = spf_pkg::DIST_W;

  typedef struct {
    logic [1:0]      mode;
    spf_pkg::coord_t cc [3];
    spf_pkg::coord_t cp [3];
    spf_pkg::coord_t oc [3];
    spf_pkg::coord_t op [3];
  } fuse_pl_t;

  logic [1:0] fusion_mode;
  logic       a_vld;
  fuse_pl_t   pl [0:DL];

  logic          dc_vld;
  logic          dp_vld;
  logic [DW-1:0] dc;
  logic [DW-1:0] dp;

  logic                        near_cur;
  logic [DW-1:0]               dn;
  logic [DW-1:0]               df;
  spf_pkg::coord_t             np;
  spf_pkg::coord_t             fp;
  logic [CW:0]                 dfar;
  logic [CW:0]                 dray;
  logic [CW:0]                 msum;
  logic [CW:0]                 mhalf;
  spf_pkg::coord_t             mean;
  spf_pkg::coord_t             base_next [3];
  logic                        neg_next  [3];
  logic [CW-1:0]               mag_next  [3];
  logic [spf_pkg::NUM_W-1:0]   num_next;
  logic [spf_pkg::DEN_W-1:0]   den_next;

  logic                        s_vld;
  spf_pkg::coord_t             s_base [3];
  logic                        s_neg  [3];
  logic [CW-1:0]               s_mag  [3];
  logic [spf_pkg::NUM_W-1:0]   s_num;
  logic [spf_pkg::DEN_W-1:0]   s_den;

  logic            bl_vld [3];
  spf_pkg::coord_t bl_res [3];

  // Register port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == spf_pkg::REG_FUSION_MODE)
                  ? {{(spf_pkg::DATA_W - 2){1'b0}}, fusion_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fusion_mode <= spf_pkg::MODE_MEAN;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == spf_pkg::REG_FUSION_MODE) begin
      fusion_mode <= pwdata[1:0];
    end
  end

  assign busy = 1'b0;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pl[0].mode  <= fusion_mode;
    pl[0].cc[0] <= cur_cam_x;
    pl[0].cc[1] <= cur_cam_y;
    pl[0].cc[2] <= cur_cam_z;
    pl[0].cp[0] <= cur_pt_x;
    pl[0].cp[1] <= cur_pt_y;
    pl[0].cp[2] <= cur_pt_z;
    pl[0].oc[0] <= old_cam_x;
    pl[0].oc[1] <= old_cam_y;
    pl[0].oc[2] <= old_cam_z;
    pl[0].op[0] <= old_pt_x;
    pl[0].op[1] <= old_pt_y;
    pl[0].op[2] <= old_pt_z;
    for (int k = 0; k < DL; k++) begin
      pl[k+1] <= pl[k];
    end
  end

  spf_dist u_dist_cur (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (a_vld),
    .pt       (pl[0].cp),
    .cam      (pl[0].cc),
    .out_vld  (dc_vld),
    .distance (dc)
  );

  spf_dist u_dist_old (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (a_vld),
    .pt       (pl[0].op),
    .cam      (pl[0].oc),
    .out_vld  (dp_vld),
    .distance (dp)
  );

  // Mode select: every mode becomes base +/- mag*num/den; pass-through cases use num zero.
  always_comb begin
    near_cur = dc < dp;
    dn       = near_cur ? dc : dp;
    df       = near_cur ? dp : dc;
    for (int i = 0; i < 3; i++) begin
      np    = near_cur ? pl[DL].cp[i] : pl[DL].op[i];
      fp    = near_cur ? pl[DL].op[i] : pl[DL].cp[i];
      dfar  = {fp[CW-1], fp} - {np[CW-1], np};
      dray  = {pl[DL].cp[i][CW-1], pl[DL].cp[i]} - {pl[DL].cc[i][CW-1], pl[DL].cc[i]};
      msum  = {pl[DL].cp[i][CW-1], pl[DL].cp[i]} + {pl[DL].op[i][CW-1], pl[DL].op[i]};
      // Halving rounded away from zero is a plain floor for negative sums.
      mhalf = msum + {{CW{1'b0}}, ~msum[CW]};
      mean  = spf_pkg::coord_t'(mhalf[CW:1]);
      neg_next[i] = 1'b0;
      mag_next[i] = '0;
      unique case (pl[DL].mode)
        spf_pkg::MODE_DIST: begin
          base_next[i] = np;
          if (df != '0) begin
            neg_next[i] = dfar[CW];
            mag_next[i] = dfar[CW] ? (~dfar[CW-1:0] + 1'b1) : dfar[CW-1:0];
          end
        end
        spf_pkg::MODE_INVD: begin
          if (dc != '0 && dp != '0) begin
            base_next[i] = pl[DL].cc[i];
            neg_next[i]  = dray[CW];
            mag_next[i]  = dray[CW] ? (~dray[CW-1:0] + 1'b1) : dray[CW-1:0];
          end else begin
            base_next[i] = pl[DL].cp[i];
          end
        end
        default: begin
          base_next[i] = mean;
        end
      endcase
    end

    num_next = '0;
    den_next = spf_pkg::DEN_W'(1);
    unique case (pl[DL].mode)
      spf_pkg::MODE_DIST: begin
        if (df != '0) begin
          num_next = {1'b0, dn};
          den_next = {df, 1'b0};
        end
      end
      spf_pkg::MODE_INVD: begin
        if (dc != '0 && dp != '0) begin
          num_next = {dp, 1'b0};
          den_next = {1'b0, dc} + {1'b0, dp};
        end
      end
      default: begin
        num_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= dc_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s_base[i] <= base_next[i];
      s_neg[i]  <= neg_next[i];
      s_mag[i]  <= mag_next[i];
    end
    s_num <= num_next;
    s_den <= den_next;
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    spf_blend u_blend (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (s_vld),
      .base    (s_base[g]),
      .neg     (s_neg[g]),
      .mag     (s_mag[g]),
      .num     (s_num),
      .den     (s_den),
      .out_vld (bl_vld[g]),
      .res     (bl_res[g])
    );
  end

  assign done    = bl_vld[0];
  assign fused_x = bl_res[0];
  assign fused_y = bl_res[1];
  assign fused_z = bl_res[2];

  `SPF_ASSERT_IMPLY(a_fixed_latency, done, $past(start, spf_pkg::TOTAL_LAT), "result without a transfer at fixed latency")
  `SPF_ASSERT_ALWAYS(a_dist_aligned, dc_vld == dp_vld, "distance pipelines out of step")
  `SPF_ASSERT_IMPLY(a_den_nonzero, s_vld, s_den != '0, "zero divisor entered the divider")
  `SPF_ASSERT_ALWAYS(a_axes_aligned, bl_vld[0] == bl_vld[1] && bl_vld[1] == bl_vld[2], "axis lanes out of step")

endmodule
